>>> rtl/core/clf_pkg.sv
// Shared types, constants and the CRC-8/Maxim byte function of the channel level framer.
package clf_pkg;

    localparam int LEVEL_COUNT   = 5;
    localparam int LEVEL_W       = 3;
    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_FLAG   = 8'h5E;
    localparam logic [7:0] ESC_ESC    = 8'h5D;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY_R = 8'h8C;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_WRAP = 3'd5;

    localparam logic [7:0] PRESS_ADVANCE = 8'd1;

    typedef logic [LEVEL_COUNT-1:0][LEVEL_W-1:0] level_vec_t;

    typedef struct packed {
        logic [7:0] channel_code;
        logic [7:0] press_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } result_t;

    typedef struct packed {
        logic [7:0] address;
        level_vec_t levels;
    } frame_job_t;

    // One byte of the reflected CRC-8 (poly 0x31), crc and data already combined.
    function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_R;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/channel_level_crc8_framer.sv
// Top level of the channel level framer: config register, front end, job queue, serializer, output queue.
//
// This block keeps five channel levels (each 1..4, reset to 1) and turns every
// command item with a known channel code into a framed byte stream: 0x7E, the
// frame address, the five levels, a CRC-8 byte (poly 0x31 reflected, init
// 0xFF; escaped as 0x7D 0x5E or 0x7D 0x5D when it collides with a delimiter)
// and a closing 0x7E marked by last_byte. Commands with an unknown channel code
// are taken and dropped with no effect. The input side accepts one command item
// per cycle while the job queue (CMD_DEPTH entries) has room, so commands can
// arrive back to back and the level update is applied at once. The serializer
// emits one frame byte per cycle into the output queue (OUT_DEPTH entries)
// while that queue has room, so one frame is 9 bytes long, or 10 when the CRC
// is escaped; the serializer sets the sustained command rate. The first byte
// of a frame reaches the result ports through the job queue and then the
// output queue. The frame address register is sampled into each job when its
// command is accepted; write it only while the block is idle.
module channel_level_crc8_framer
    import clf_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       push,
    output logic       full,
    input  cmd_t       cmd_item,
    output logic       empty,
    input  logic       pop,
    output result_t    result_item
);

    localparam int JOB_W = $bits(frame_job_t);
    localparam int RES_W = $bits(result_t);

    logic [7:0]       frame_address_reg;
    logic             accept;
    logic             job_push, job_pop, job_empty;
    frame_job_t       job_wr, job_head;
    logic [JOB_W-1:0] job_rd_bits;
    logic             out_push, out_full;
    result_t          out_wr;
    logic [RES_W-1:0] out_rd_bits;

    // The frame address is a plain register with no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            frame_address_reg <= cfg_wdata;
        end
    end

    // Every item is taken while the job queue has room, including ones that
    // turn out to carry an unknown channel code.
    assign accept = push && !full;

    clf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd_item      (cmd_item),
        .frame_address (frame_address_reg),
        .job_push      (job_push),
        .job_data      (job_wr)
    );

    // Jobs carry a snapshot of the address and all five levels, so the front
    // end may keep changing levels while earlier frames are still going out.
    clf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (CMD_DEPTH)
    ) u_job_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wr),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_rd_bits),
        .empty   (job_empty)
    );

    assign job_head = frame_job_t'(job_rd_bits);

    clf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_wr)
    );

    // The output queue decouples the serializer from the consumer's pop.
    clf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wr),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_bits),
        .empty   (empty)
    );

    assign result_item = result_t'(out_rd_bits);

    // A job leaves the queue only together with the closing delimiter it produces.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (out_push && out_wr.last_byte && (out_wr.frame_byte == FLAG_BYTE)))
        else $error("job retired without its closing delimiter");

    // The serializer never writes into a full output queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("output queue overflow");

    // Any item marked last on the result ports is the closing delimiter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_item.last_byte) |-> (result_item.frame_byte == FLAG_BYTE))
        else $error("last byte is not a delimiter");

endmodule

>>> rtl/core/clf_fifo.sv
// Small first-word-fall-through queue used for the command queue and the output queue.
module clf_fifo
    import clf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/clf_front.sv
// Command front end: decodes the channel code, updates the levels and queues a frame job.
module clf_front
    import clf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  cmd_t       cmd_item,
    input  logic [7:0] frame_address,
    output logic       job_push,
    output frame_job_t job_data
);

    level_vec_t       levels_reg, levels_next;
    logic             cmd_valid;
    logic [2:0]       sel;
    logic [LEVEL_W-1:0] lv_inc;

    always_comb
    begin
        cmd_valid = 1'b1;
        sel       = '0;
        if (cmd_item.channel_code inside {[8'd1:8'd5]})
        begin
            sel = cmd_item.channel_code[2:0] - 3'd1;
        end
        else if (cmd_item.channel_code inside {8'd6, 8'd7})
        begin
            sel = 3'(LEVEL_COUNT - 1);
        end
        else
        begin
            cmd_valid = 1'b0;
        end
    end

    always_comb
    begin
        levels_next = levels_reg;
        lv_inc      = levels_reg[sel] + 1'b1;
        if (lv_inc == LEVEL_WRAP)
        begin
            lv_inc = LEVEL_ONE;
        end
        if (accept && cmd_valid && (cmd_item.press_code == PRESS_ADVANCE))
        begin
            levels_next[sel] = lv_inc;
        end
    end

    assign job_push         = accept && cmd_valid;
    assign job_data.address = frame_address;
    assign job_data.levels  = levels_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LEVEL_COUNT; k++)
            begin
                levels_reg[k] <= LEVEL_ONE;
            end
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

endmodule

>>> rtl/core/clf_back.sv
// Frame serializer: walks one queued job byte by byte, folding the CRC as it goes.
module clf_back
    import clf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  frame_job_t job_head,
    output logic       job_pop,
    input  logic       out_full,
    output logic       out_push,
    output result_t    out_data
);

    localparam logic [3:0] ST_OPEN  = 4'd0;
    localparam logic [3:0] ST_ADDR  = 4'd1;
    localparam logic [3:0] ST_LV0   = 4'd2;
    localparam logic [3:0] ST_LV1   = 4'd3;
    localparam logic [3:0] ST_LV2   = 4'd4;
    localparam logic [3:0] ST_LV3   = 4'd5;
    localparam logic [3:0] ST_LV4   = 4'd6;
    localparam logic [3:0] ST_CRC   = 4'd7;
    localparam logic [3:0] ST_ESC2  = 4'd8;
    localparam logic [3:0] ST_CLOSE = 4'd9;

    logic [3:0] step_reg, step_next;
    logic [7:0] crc_reg, crc_next;
    logic       advance;
    logic [2:0] lv_off;
    logic [7:0] lv_byte;
    logic       crc_is_flag, crc_is_esc;

    assign advance     = job_valid && !out_full;
    assign lv_off      = step_reg[2:0] - ST_LV0[2:0];
    assign lv_byte     = {5'b0, job_head.levels[lv_off]};
    assign crc_is_flag = (crc_reg == FLAG_BYTE);
    assign crc_is_esc  = (crc_reg == ESC_BYTE);

    always_comb
    begin
        step_next          = step_reg;
        crc_next           = crc_reg;
        out_data.frame_byte = FLAG_BYTE;
        out_data.last_byte  = 1'b0;
        job_pop            = 1'b0;
        case (step_reg)
            ST_OPEN:
            begin
                out_data.frame_byte = FLAG_BYTE;
                step_next           = ST_ADDR;
            end
            ST_ADDR:
            begin
                out_data.frame_byte = job_head.address;
                crc_next            = crc8_maxim_byte(CRC_INIT ^ job_head.address);
                step_next           = ST_LV0;
            end
            ST_LV0, ST_LV1, ST_LV2, ST_LV3, ST_LV4:
            begin
                out_data.frame_byte = lv_byte;
                crc_next            = crc8_maxim_byte(crc_reg ^ lv_byte);
                step_next           = step_reg + 1'b1;
            end
            ST_CRC:
            begin
                if (crc_is_flag || crc_is_esc)
                begin
                    out_data.frame_byte = ESC_BYTE;
                    step_next           = ST_ESC2;
                end
                else
                begin
                    out_data.frame_byte = crc_reg;
                    step_next           = ST_CLOSE;
                end
            end
            ST_ESC2:
            begin
                out_data.frame_byte = crc_is_flag ? ESC_FLAG : ESC_ESC;
                step_next           = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                out_data.frame_byte = FLAG_BYTE;
                out_data.last_byte  = 1'b1;
                job_pop             = advance;
                step_next           = ST_OPEN;
            end
            default:
            begin
                step_next = ST_OPEN;
            end
        endcase
    end

    assign out_push = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_OPEN;
            crc_reg  <= CRC_INIT;
        end
        else if (advance)
        begin
            step_reg <= step_next;
            crc_reg  <= crc_next;
        end
    end

endmodule
